@@ sv/pls_pkg.sv @@
// Package for the positional list store: field widths, command and status codes,
// and the control word that is broadcast to every storage cell.
// No dependencies.
`default_nettype none

package pls_pkg;

  // Default number of list slots
  localparam int CAPACITY_DEF = 16;

  // Fixed field widths
  localparam int CmdW  = 2;
  localparam int PosW  = 8;
  localparam int DataW = 32;
  localparam int StatW = 2;
  localparam int LenW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_NULL   = 2'd3
  } status_t;

  // Broadcast to all cells for one beat
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] wdata;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/pls_ifs.sv @@
// Valid/ready channel interfaces for the positional list store: command
// channel and result channel. Depends on pls_pkg for field widths.
`default_nettype none

interface pls_in_if;
  logic                       valid;
  logic                       ready;
  logic [pls_pkg::CmdW-1:0]   cmd;
  logic [pls_pkg::PosW-1:0]   position;
  logic [pls_pkg::DataW-1:0]  entry_value;

  modport source (output valid, output cmd, output position, output entry_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input entry_value,
                  output ready);
endinterface

interface pls_out_if;
  logic                       valid;
  logic                       ready;
  logic [pls_pkg::StatW-1:0]  status;
  logic [pls_pkg::DataW-1:0]  read_value;
  logic [pls_pkg::LenW-1:0]   list_length;

  modport source (output valid, output status, output read_value, output list_length,
                  input ready);
  modport sink   (input valid, input status, input read_value, input list_length,
                  output ready);
endinterface

`default_nettype wire

@@ sv/pls_cell.sv @@
// One storage cell of the positional list: holds one word and, on each beat,
// takes a new word, its lower neighbor's word, its upper neighbor's word, or holds.
// Depends on pls_pkg.
`default_nettype none

module pls_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  pls_pkg::cell_ctl_t        ctl,
  input  logic [pls_pkg::DataW-1:0] prev_q,
  input  logic [pls_pkg::DataW-1:0] next_q,
  output logic [pls_pkg::DataW-1:0] entry_q
);
  import pls_pkg::*;

  localparam logic [PosW-1:0] MyPos = PosW'(IDX);

  logic [DataW-1:0] entry_r;
  logic [DataW-1:0] entry_nxt;

  // Pick this cell's next word from its own index against the broadcast position
  always_comb begin
    priority if (ctl.ins_en && (ctl.pos == MyPos)) begin
      entry_nxt = ctl.wdata;
    end else if (ctl.ins_en && (MyPos > ctl.pos)) begin
      entry_nxt = prev_q;
    end else if (ctl.del_en && (MyPos >= ctl.pos)) begin
      entry_nxt = next_q;
    end else begin
      entry_nxt = entry_r;
    end
  end

  // Hold the word; payload needs no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

`default_nettype wire

@@ sv/positional_list_store_core.sv @@
// Top level of the positional list store: length counter, command decode,
// row of pls_cell storage cells and the registered result stage.
// Depends on pls_pkg, pls_in_if, pls_out_if and pls_cell.
//
//   channel   dir  beat contents                          handshake
//   in_ch     in   cmd, position, entry_value             valid/ready
//   out_ch    out  status, read_value, list_length        valid/ready
//
// Every command finishes in the cycle its beat is accepted; the result beat is
// offered on the next cycle from the output register, so one command per cycle while out_ch takes results.
// All cells shift in parallel, each comparing its own index with the position.
// Reset clears the length and the output valid; stored words are not cleared.
// A result waiting on out_ch blocks new commands only while out_ch.ready is low.
`default_nettype none

module positional_list_store_core #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pls_in_if.sink    in_ch,
  pls_out_if.source out_ch
);
  import pls_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [CntW-1:0]  count_r;
  logic [CntW-1:0]  count_nxt;
  logic             out_valid_r;
  status_t          status_r;
  status_t          status_nxt;
  logic [DataW-1:0] value_r;
  logic [DataW-1:0] value_nxt;
  logic [LenW-1:0]  len_r;

  logic             accept;
  cmd_t             cmd;
  logic             full;
  logic             beyond_cap;
  logic             in_list;
  logic [DataW-1:0] rd_word;
  cell_ctl_t        ctl;

  logic [DataW-1:0] entry_q [CAPACITY];
  logic [DataW-1:0] prev_q  [CAPACITY];
  logic [DataW-1:0] next_q  [CAPACITY];

  // Accept a beat whenever the result register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);

  // Position checks
  assign full       = (count_r == CntW'(CAPACITY));
  assign beyond_cap = (in_ch.position >= PosW'(CAPACITY));
  assign in_list    = (in_ch.position < PosW'(count_r));
  assign rd_word    = entry_q[in_ch.position[IdxW-1:0]];

  // Decode the command into a cell broadcast and the result fields
  always_comb begin
    status_nxt = ST_OK;
    value_nxt  = '0;
    count_nxt  = count_r;
    ctl.ins_en = 1'b0;
    ctl.del_en = 1'b0;
    ctl.pos    = in_ch.position;
    ctl.wdata  = in_ch.entry_value;
    if (accept) begin
      unique case (cmd)
        CMD_INSERT: begin
          priority if (in_ch.entry_value == '0) begin
            status_nxt = ST_NULL;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else if (beyond_cap) begin
            status_nxt = ST_BADPOS;
          end else begin
            ctl.ins_en = 1'b1;
            // Clamp to append
            if (!in_list) begin
              ctl.pos = PosW'(count_r);
            end
            count_nxt = count_r + CntW'(1);
          end
        end
        CMD_GET: begin
          if (!in_list) begin
            status_nxt = ST_BADPOS;
          end else begin
            value_nxt = rd_word;
          end
        end
        CMD_DELETE: begin
          if (!in_list) begin
            status_nxt = ST_BADPOS;
          end else begin
            value_nxt  = rd_word;
            ctl.del_en = 1'b1;
            count_nxt  = count_r - CntW'(1);
          end
        end
        CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Wire neighbors along the row; the ends see zero
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      prev_q[i] = (i == 0) ? '0 : entry_q[(i == 0) ? 0 : i - 1];
      next_q[i] = (i == CAPACITY - 1) ? '0 : entry_q[(i == CAPACITY - 1) ? i : i + 1];
    end
  end

  // Row of storage cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    pls_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .prev_q  (prev_q[g]),
      .next_q  (next_q[g]),
      .entry_q (entry_q[g])
    );
  end

  // Advance the length counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      len_r    <= LenW'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.read_value  = value_r;
  assign out_ch.list_length = len_r;

`ifndef ASSERT_OFF
  // Length never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("list length above capacity");

  // Clear empties the list
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.cmd == CMD_CLEAR) |=> (count_r == '0) && (status_r == ST_OK))
    else $error("clear did not empty the list");

  // Null insert leaves the list alone
  a_null_insert: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_ch.cmd == CMD_INSERT) && (in_ch.entry_value == '0)
    |=> (status_r == ST_NULL) && (count_r == $past(count_r)))
    else $error("null insert changed the list");

  // Successful insert grows the list by one
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctl.ins_en |=> (count_r == $past(count_r) + CntW'(1)))
    else $error("insert did not grow the list");

  // Failed commands return a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> (value_r == '0))
    else $error("error result carries a word");
`endif

endmodule

`default_nettype wire

@@ tb/tb_positional_list_store_core.sv @@
// Testbench for positional_list_store_core: directed and random list commands with
// a local list predictor, random idling on both channels and an output hold-off.
// Depends on pls_pkg, pls_in_if, pls_out_if and the positional_list_store_core RTL.
`default_nettype none

module tb_positional_list_store_core;
  import pls_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int LIST_IDX_W = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    status_t          status;
    logic [DataW-1:0] value;
    logic [LenW-1:0]  length;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pls_in_if  in_ch ();
  pls_out_if out_ch ();

  positional_list_store_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted list contents and the results still owed by the block
  bit [DataW-1:0] list_words [LIST_CAP];
  int             list_len;
  list_result_t   pending_results [$];

  int error_count;
  bit in_idle_en;
  bit out_idle_en;
  bit hold_pending;

  always #4 clk = ~clk;

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Apply one command to the predicted list and return the result it should give
  function automatic list_result_t apply_list_cmd(cmd_t c, bit [PosW-1:0] p,
                                                  bit [DataW-1:0] v);
    list_result_t r;
    int at;
    r.status = ST_OK;
    r.value  = '0;
    case (c)
      CMD_INSERT: begin
        if (v == 0) r.status = ST_NULL;
        else if (list_len >= LIST_CAP) r.status = ST_FULL;
        else if (p >= LIST_CAP) r.status = ST_BADPOS;
        else begin
          at = (p > list_len) ? list_len : p;
          for (int k = list_len; k > at; k--) list_words[k] = list_words[k-1];
          list_words[at] = v;
          list_len++;
        end
      end
      CMD_GET: begin
        if (p >= list_len) r.status = ST_BADPOS;
        else r.value = list_words[p[LIST_IDX_W-1:0]];
      end
      CMD_DELETE: begin
        if (p >= list_len) r.status = ST_BADPOS;
        else begin
          r.value = list_words[p[LIST_IDX_W-1:0]];
          for (int k = p + 1; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
        end
      end
      default: list_len = 0;
    endcase
    r.length = LenW'(list_len);
    return r;
  endfunction

  // Offer one command beat, hold it until accepted, then record its result
  task automatic send_cmd(cmd_t c, bit [PosW-1:0] p, bit [DataW-1:0] v);
    if (in_idle_en && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.position    <= p;
    in_ch.entry_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(apply_list_cmd(c, p, v));
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Mostly well-formed commands: positions inside the list, with some noise
  task automatic send_random_cmd();
    int pick;
    int ins_share;
    cmd_t c;
    bit [PosW-1:0] p;
    bit [DataW-1:0] v;
    pick = $urandom_range(99);
    ins_share = (list_len > 12) ? 30 : 46;
    v = $urandom;
    if ($urandom_range(39) == 0) v = '0;
    if (pick < ins_share) begin
      c = CMD_INSERT;
      if ($urandom_range(9) == 0) p = PosW'($urandom_range(255));
      else p = PosW'($urandom_range(0, list_len));
    end else if (pick < 97) begin
      c = (pick < (ins_share + 97) / 2) ? CMD_GET : CMD_DELETE;
      if ($urandom_range(9) == 0 || list_len == 0) p = PosW'($urandom_range(255));
      else p = PosW'($urandom_range(0, list_len - 1));
    end else begin
      c = CMD_CLEAR;
      p = PosW'($urandom_range(255));
    end
    send_cmd(c, p, v);
  endtask

  // Empty list: reads fail, clear works, null insert is refused
  task automatic test_empty_list();
    send_cmd(CMD_GET, 8'd0, 32'h1234_5678);
    send_cmd(CMD_DELETE, 8'd0, '0);
    send_cmd(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 8'd0, '0);
    send_cmd(CMD_INSERT, 8'hFF, 32'hA5A5_5A5A);
    drain_results();
  endtask

  // Append past the length, fill to capacity, then hit the full and null checks
  task automatic test_fill_and_limits();
    send_cmd(CMD_INSERT, 8'(LIST_CAP - 1), 32'hFFFF_FFFF);
    send_cmd(CMD_INSERT, 8'd0, 32'h0000_0001);
    for (int k = 0; k < LIST_CAP - 2; k++)
      send_cmd(CMD_INSERT, 8'($urandom_range(0, list_len)), $urandom | 32'h1);
    send_cmd(CMD_INSERT, 8'hFF, 32'h8000_0000);
    send_cmd(CMD_INSERT, 8'd3, '0);
    drain_results();
  endtask

  // Read and remove at both ends and in the middle, then clear
  task automatic test_remove_and_clear();
    send_cmd(CMD_GET, 8'(LIST_CAP - 1), '0);
    send_cmd(CMD_GET, 8'(LIST_CAP), '0);
    send_cmd(CMD_DELETE, 8'(LIST_CAP - 1), '0);
    send_cmd(CMD_DELETE, 8'd0, '0);
    send_cmd(CMD_DELETE, 8'd6, '0);
    send_cmd(CMD_DELETE, 8'hFF, '0);
    send_cmd(CMD_CLEAR, 8'd0, '0);
    send_cmd(CMD_GET, 8'd0, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_cmd();
    drain_results();
  endtask

  // Hold the result channel while commands keep coming, so the input stalls
  task automatic test_output_holdoff();
    hold_pending = 1'b1;
    repeat (24) send_random_cmd();
    drain_results();
  endtask

  // Result beats: pop the oldest expectation and compare every field
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result beat with no command pending");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          flag_error($sformatf("status %0d, expected %0d", out_ch.status, want.status));
        if (out_ch.read_value !== want.value)
          flag_error($sformatf("read_value %h, expected %h", out_ch.read_value,
                               want.value));
        if (out_ch.list_length !== want.length)
          flag_error($sformatf("list_length %0d, expected %0d", out_ch.list_length,
                               want.length));
      end
    end
  end

  // Result channel ready: random stalls, or a counted hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (out_idle_en && $urandom_range(99) < 20) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_positional_list_store_core failed");
    $finish;
  end

  initial begin
    error_count  = 0;
    list_len     = 0;
    hold_pending = 1'b0;
    in_idle_en   = 1'b1;
    out_idle_en  = 1'b1;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_GET;
    in_ch.position    <= '0;
    in_ch.entry_value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_fill_and_limits();
    test_remove_and_clear();
    test_random_traffic(600);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random_traffic(400);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    test_output_holdoff();
    test_random_traffic(600);

    drain_results();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_positional_list_store_core passed");
    end else begin
      $display("tb_positional_list_store_core failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
